// ===== hdl/bums_pkg.sv =====
// ----------------------------------------------------------------------------
// bums_pkg
// Shared types and constants for the bottom-up merge sorter.
// ----------------------------------------------------------------------------
package bums_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

// ===== hdl/bums_ram.sv =====
// ----------------------------------------------------------------------------
// bums_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module bums_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bottom_up_merge_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// bottom_up_merge_sorter_unit
// Collects signed values until one is marked last, sorts the set ascending
// with bottom-up merge sort over two ping-pong RAM banks, then streams it out.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     in_value, in_is_last                    start & !busy
//  result    out_sorted_value, out_end_of_set        out_strobe, one cycle
//
//  Loading accepts one request per cycle; busy stays low between requests.
//  After the last request busy rises for the sort: ceil(log2 n) passes, each
//  merging run pairs via the single RAM read port and the one comparator:
//  fetch both heads, then write an element and refill its run's head.
//  Results then follow back to back. Reset clears only control state; the RAMs
//  need no clearing. The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module bottom_up_merge_sorter_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bums_pkg::data_t     in_value,
  input  logic                in_is_last,
  output logic                out_strobe,
  output bums_pkg::data_t     out_sorted_value,
  output logic                out_end_of_set
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int SW = CW + 2;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_FA   = 3'd2;
  localparam logic [2:0] S_FB   = 3'd3;
  localparam logic [2:0] S_CB   = 3'd4;
  localparam logic [2:0] S_MRG  = 3'd5;
  localparam logic [2:0] S_REF  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW:0]     w_r, w_nxt;
  logic [CW-1:0]   lo_r, lo_nxt;
  logic [CW-1:0]   a_r, a_nxt;
  logic [CW-1:0]   b_r, b_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   md_r, md_nxt;
  logic [CW-1:0]   hi_r, hi_nxt;
  logic            bank_r, bank_nxt;
  logic            took_a_r, took_a_nxt;
  bums_pkg::data_t head_a_r, head_a_nxt;
  bums_pkg::data_t head_b_r, head_b_nxt;
  logic            strobe_r, strobe_nxt;
  logic            last_r, last_nxt;

  logic [SW-1:0]   end_a, end_b;
  logic [CW:0]     w_dbl;
  logic            take_a;
  logic            accept;
  logic [CW-1:0]   cnt_inc;

  // RAM controls: src bank is bank_r, destination is the other one
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  bums_pkg::data_t wr_data;
  logic            wr_bank;
  logic [bums_pkg::DATA_W-1:0] rd0, rd1;
  bums_pkg::data_t rd_data;

  assign accept  = start && !busy;
  assign busy    = (state_r != S_LOAD);
  assign end_a   = SW'(lo_r) + SW'(w_r);
  assign end_b   = end_a + SW'(w_r);
  assign w_dbl   = {w_r[CW-1:0], 1'b0};
  assign cnt_inc = (cnt_r < CW'(MAX_ITEMS)) ? cnt_r + CW'(1) : cnt_r;
  assign rd_data = bank_r ? bums_pkg::data_t'(rd1) : bums_pkg::data_t'(rd0);
  // equal heads: right run goes first
  assign take_a  = (a_r < md_r) && ((b_r >= hi_r) || (head_a_r < head_b_r));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    w_nxt      = w_r;
    lo_nxt     = lo_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    k_nxt      = k_r;
    md_nxt     = md_r;
    hi_nxt     = hi_r;
    bank_nxt   = bank_r;
    took_a_nxt = took_a_r;
    head_a_nxt = head_a_r;
    head_b_nxt = head_b_r;
    strobe_nxt = 1'b0;
    last_nxt   = 1'b0;
    wr_en      = 1'b0;
    wr_bank    = 1'b0;
    wr_addr    = cnt_r[AW-1:0];
    wr_data    = in_value;
    rd_en      = 1'b0;
    rd_addr    = a_r[AW-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          wr_en   = (cnt_r < CW'(MAX_ITEMS));
          cnt_nxt = cnt_inc;
          if (in_is_last) begin
            cnt_nxt  = '0;
            n_nxt    = cnt_inc;
            w_nxt    = (CW+1)'(1);
            lo_nxt   = '0;
            k_nxt    = '0;
            bank_nxt = 1'b0;
            state_nxt = (cnt_inc == CW'(1)) ? S_EMIT : S_RUN;
          end
        end
      end
      S_RUN: begin
        if (lo_r >= n_r) begin
          // pass finished: merged data now sits in the other bank
          bank_nxt = !bank_r;
          w_nxt    = w_dbl;
          lo_nxt   = '0;
          k_nxt    = '0;
          if ((CW+1)'(n_r) <= w_dbl) begin
            state_nxt = S_EMIT;
          end
        end else begin
          md_nxt    = (end_a < SW'(n_r)) ? end_a[CW-1:0] : n_r;
          hi_nxt    = (end_b < SW'(n_r)) ? end_b[CW-1:0] : n_r;
          a_nxt     = lo_r;
          b_nxt     = (end_a < SW'(n_r)) ? end_a[CW-1:0] : n_r;
          k_nxt     = lo_r;
          state_nxt = S_FA;
        end
      end
      S_FA: begin
        rd_en     = 1'b1;
        rd_addr   = a_r[AW-1:0];
        state_nxt = S_FB;
      end
      S_FB: begin
        rd_en      = 1'b1;
        rd_addr    = b_r[AW-1:0];
        head_a_nxt = rd_data;
        state_nxt  = S_CB;
      end
      S_CB: begin
        head_b_nxt = rd_data;
        state_nxt  = S_MRG;
      end
      S_MRG: begin
        if (k_r == hi_r) begin
          lo_nxt    = hi_r;
          state_nxt = S_RUN;
        end else begin
          wr_en      = 1'b1;
          wr_bank    = !bank_r;
          wr_addr    = k_r[AW-1:0];
          wr_data    = take_a ? head_a_r : head_b_r;
          k_nxt      = k_r + CW'(1);
          rd_en      = 1'b1;
          took_a_nxt = take_a;
          if (take_a) begin
            a_nxt   = a_r + CW'(1);
            rd_addr = a_nxt[AW-1:0];
          end else begin
            b_nxt   = b_r + CW'(1);
            rd_addr = b_nxt[AW-1:0];
          end
          state_nxt = S_REF;
        end
      end
      S_REF: begin
        if (took_a_r) begin
          head_a_nxt = rd_data;
        end else begin
          head_b_nxt = rd_data;
        end
        state_nxt = S_MRG;
      end
      S_EMIT: begin
        rd_en      = 1'b1;
        rd_addr    = k_r[AW-1:0];
        strobe_nxt = 1'b1;
        last_nxt   = (k_r + CW'(1) == n_r);
        k_nxt      = k_r + CW'(1);
        if (k_r + CW'(1) == n_r) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
      bank_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
      bank_r   <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    w_r      <= w_nxt;
    lo_r     <= lo_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    k_r      <= k_nxt;
    md_r     <= md_nxt;
    hi_r     <= hi_nxt;
    took_a_r <= took_a_nxt;
    head_a_r <= head_a_nxt;
    head_b_r <= head_b_nxt;
  end

  bums_ram #(
    .WIDTH (bums_pkg::DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_bank0 (
    .clk   (clk),
    .we    (wr_en && !wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en && !bank_r),
    .raddr (rd_addr),
    .rdata (rd0)
  );

  bums_ram #(
    .WIDTH (bums_pkg::DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_bank1 (
    .clk   (clk),
    .we    (wr_en && wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en && bank_r),
    .raddr (rd_addr),
    .rdata (rd1)
  );

  assign out_strobe       = strobe_r;
  assign out_end_of_set   = strobe_r && last_r;
  assign out_sorted_value = rd_data;

endmodule

// ===== hdl/bums_checker.sv =====
// ----------------------------------------------------------------------------
// bums_checker
// Port-level checks on the sorter's request and result timing.
// ----------------------------------------------------------------------------
module bums_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            in_is_last,
  input logic            out_strobe,
  input logic            out_end_of_set
);

  a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_of_set |-> out_strobe)
    else $error("end_of_set without strobe");

  a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_end_of_set) |-> busy)
    else $error("unit idle while set not fully emitted");

  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_end_of_set) |=> out_strobe)
    else $error("gap inside result burst");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_is_last) |=> !busy)
    else $error("load request did not complete in one cycle");

  a_last_sorts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_is_last) |=> busy)
    else $error("last request did not start the sort");

endmodule

bind bottom_up_merge_sorter_unit bums_checker u_bums_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_is_last       (in_is_last),
  .out_strobe       (out_strobe),
  .out_end_of_set   (out_end_of_set)
);
